// ===== hw/rtl/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the hierarchy path sum block: default
// sizes, status codes and the control and status words of the queue.
// ----------------------------------------------------------------------------
package hps_pkg;

    // Default sizes.
    localparam int HPS_MAX_NODES  = 1024;
    localparam int HPS_VALUE_BITS = 32;

    // Width of a child count as it arrives on the input word.
    localparam int CNT_W = 11;

    // Result status codes, lowest nonzero code wins.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_PARENT  = 3'd1,
        ST_QUEUE_FULL = 3'd2,
        ST_SATURATED  = 3'd3,
        ST_PENDING    = 3'd4
    } hps_status_t;

    // Commands from the datapath to the pending queue.
    typedef struct packed {
        logic             step;      // non-root node accepted
        logic             clear;     // root item accepted
        logic             push_req;  // node has children
        logic [CNT_W-1:0] push_cnt;  // its child count
    } hps_cmd_t;

    // Queue status back to the datapath.
    typedef struct packed {
        logic head_valid;    // a parent entry is at the head
        logic push_drop;     // this push found the queue full
        logic left_pending;  // queue not empty after this node
    } hps_qstat_t;

endpackage

// ===== hw/rtl/hps_queue.sv =====
// ----------------------------------------------------------------------------
// hps_queue
// Pending-parent queue. The head entry and the one behind it sit in
// registers; all further entries live in a synchronous memory whose read
// data is registered and fetched one entry ahead, so a pop per cycle holds.
// ----------------------------------------------------------------------------
module hps_queue
    import hps_pkg::*;
#(
    parameter int MAX_NODES  = HPS_MAX_NODES,
    parameter int VALUE_BITS = HPS_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hps_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] push_sum,
    output hps_qstat_t            qstat,
    output logic [VALUE_BITS-1:0] head_sum
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FW = $clog2(MAX_NODES + 1);
    localparam int W  = VALUE_BITS;

    // Head entry.
    logic             h_valid_reg, h_valid_next;
    logic [W-1:0]     h_sum_reg, h_sum_next;
    logic [CNT_W-1:0] h_cnt_reg, h_cnt_next;

    // Second entry, either held here or in the memory read register.
    logic             r_valid_reg, r_valid_next;
    logic             r_mem_reg, r_mem_next;
    logic [W-1:0]     r_sum_reg, r_sum_next;
    logic [CNT_W-1:0] r_cnt_reg, r_cnt_next;

    // Memory pointers and total fill.
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0]    fill_reg, fill_next;

    // Memory and its registered read port.
    logic [W-1:0]     mem_sum [MAX_NODES];
    logic [CNT_W-1:0] mem_cnt [MAX_NODES];
    logic [W-1:0]     mem_rsum_reg;
    logic [CNT_W-1:0] mem_rcnt_reg;
    logic             mem_we, mem_re;

    logic [W-1:0]     r_sum_eff;
    logic [CNT_W-1:0] r_cnt_eff;
    logic             pop, push_ok;
    logic [FW-1:0]    fill_after, mcount;
    logic [AW-1:0]    rd_ptr_inc, wr_ptr_inc;

    // Second entry as seen by the logic.
    assign r_sum_eff = r_mem_reg ? mem_rsum_reg : r_sum_reg;
    assign r_cnt_eff = r_mem_reg ? mem_rcnt_reg : r_cnt_reg;

    // The head is popped when its last child takes it.
    assign pop        = cmd.step && h_valid_reg && (h_cnt_reg <= CNT_W'(1));
    assign fill_after = fill_reg - FW'(pop);
    assign push_ok    = cmd.push_req && (fill_after < FW'(MAX_NODES));
    assign mcount     = fill_reg - FW'(h_valid_reg) - FW'(r_valid_reg);

    // Circular pointer increments.
    assign rd_ptr_inc = (rd_ptr_reg == AW'(MAX_NODES - 1)) ? '0 : rd_ptr_reg + AW'(1);
    assign wr_ptr_inc = (wr_ptr_reg == AW'(MAX_NODES - 1)) ? '0 : wr_ptr_reg + AW'(1);

    // Next state of the register stages and pointers.
    always_comb
    begin
        h_valid_next = h_valid_reg;
        h_sum_next   = h_sum_reg;
        h_cnt_next   = h_cnt_reg;
        r_valid_next = r_valid_reg;
        r_mem_next   = r_mem_reg;
        r_sum_next   = r_sum_reg;
        r_cnt_next   = r_cnt_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (cmd.clear)
        begin
            h_valid_next = cmd.push_req;
            h_sum_next   = push_sum;
            h_cnt_next   = cmd.push_cnt;
            r_valid_next = 1'b0;
            r_mem_next   = 1'b0;
            rd_ptr_next  = '0;
            wr_ptr_next  = '0;
            fill_next    = FW'(cmd.push_req);
        end
        else if (cmd.step)
        begin
            if (pop)
            begin
                if (r_valid_reg)
                begin
                    // Second entry moves up to the head.
                    h_sum_next = r_sum_eff;
                    h_cnt_next = r_cnt_eff;
                    if (mcount != '0)
                    begin
                        mem_re      = 1'b1;
                        r_mem_next  = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                        if (push_ok)
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                        end
                    end
                    else if (push_ok)
                    begin
                        r_sum_next = push_sum;
                        r_cnt_next = cmd.push_cnt;
                        r_mem_next = 1'b0;
                    end
                    else
                    begin
                        r_valid_next = 1'b0;
                    end
                end
                else if (push_ok)
                begin
                    h_sum_next = push_sum;
                    h_cnt_next = cmd.push_cnt;
                end
                else
                begin
                    h_valid_next = 1'b0;
                end
            end
            else if (h_valid_reg)
            begin
                // Head keeps waiting for more children.
                h_cnt_next = h_cnt_reg - CNT_W'(1);
                if (push_ok)
                begin
                    if (!r_valid_reg)
                    begin
                        r_valid_next = 1'b1;
                        r_mem_next   = 1'b0;
                        r_sum_next   = push_sum;
                        r_cnt_next   = cmd.push_cnt;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                    end
                end
            end
            else if (push_ok)
            begin
                // Empty queue: the orphan's entry becomes the head.
                h_valid_next = 1'b1;
                h_sum_next   = push_sum;
                h_cnt_next   = cmd.push_cnt;
            end
            fill_next = fill_after + FW'(push_ok);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            r_mem_reg   <= 1'b0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            h_valid_reg <= h_valid_next;
            r_valid_reg <= r_valid_next;
            r_mem_reg   <= r_mem_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        h_sum_reg <= h_sum_next;
        h_cnt_reg <= h_cnt_next;
        r_sum_reg <= r_sum_next;
        r_cnt_reg <= r_cnt_next;
    end

    // Queue memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_sum[wr_ptr_reg] <= push_sum;
            mem_cnt[wr_ptr_reg] <= cmd.push_cnt;
        end
        if (mem_re)
        begin
            mem_rsum_reg <= mem_sum[rd_ptr_reg];
            mem_rcnt_reg <= mem_cnt[rd_ptr_reg];
        end
    end

    // Status back to the datapath.
    assign head_sum           = h_sum_reg;
    assign qstat.head_valid   = h_valid_reg;
    assign qstat.push_drop    = cmd.step && cmd.push_req && !push_ok;
    assign qstat.left_pending = (fill_next != '0);

    // The fill never goes past the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_NODES))
        else $error("queue fill exceeds capacity");

    // An empty head means an empty queue.
    a_head_first: assert property (@(posedge clk) disable iff (!rst_n)
        !h_valid_reg |-> (fill_reg == '0))
        else $error("entries queued behind an empty head");

    // Without a second entry only the head can be queued.
    a_second_first: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid_reg |-> (fill_reg <= FW'(1)))
        else $error("memory holds entries while the second stage is empty");

    // A memory read is only issued while entries are stored there.
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (mcount != '0) && r_valid_reg)
        else $error("memory read with no stored entry");

endmodule

// ===== hw/rtl/hierarchy_path_sum.sv =====
// ----------------------------------------------------------------------------
// hierarchy_path_sum
// Path sums over a breadth-first labelled class tree: each node's result is
// its own value plus its parent's saturated sum, parents taken from a queue.
// ----------------------------------------------------------------------------
// A node's result word is valid in the cycle after the node is taken.
// Throughput: one node per cycle while no result is stalled; the head entry
// and its successor are kept in registers and the queue memory is read one
// entry ahead. Root items are taken at the same rate and give no result word.
// Reset (asynchronous, active low) empties the queue and the output stage;
// the queue memory is not cleared, since an entry is read only after writing.
// ----------------------------------------------------------------------------
module hierarchy_path_sum
    import hps_pkg::*;
#(
    parameter int MAX_NODES  = HPS_MAX_NODES,
    parameter int VALUE_BITS = HPS_VALUE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] node_value, [42:32] child_count, rest zero
    input  logic        s_tlast,   // last_node
    input  logic [0:0]  s_tuser,   // [0] root_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] node_sum
    output logic        m_tlast,   // row_end
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int W     = VALUE_BITS;
    localparam int EXT_W = 96;

    logic             accept, root;
    logic [EXT_W-1:0] in_ext, sum_ext;
    logic [W-1:0]     value_w, parent_w, raw_w, sum_w, push_sum, head_sum;
    logic [CNT_W-1:0] child_count;
    logic             ovf;
    hps_cmd_t         cmd;
    hps_qstat_t       qstat;
    hps_status_t      status;

    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_sum_reg;
    logic             out_last_reg;
    hps_status_t      out_status_reg;

    // Input handshake: the output stage frees up as it drains.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign root     = s_tuser[0];

    // Field extraction; the value is taken as VALUE_BITS wide.
    assign in_ext      = EXT_W'(s_tdata[31:0]);
    assign value_w     = in_ext[W-1:0];
    assign child_count = s_tdata[42:32];

    // Saturating add of the node value and the parent sum.
    assign parent_w = qstat.head_valid ? head_sum : '0;
    assign raw_w    = value_w + parent_w;
    assign ovf      = (value_w[W-1] == parent_w[W-1]) && (raw_w[W-1] != value_w[W-1]);
    assign sum_w    = !ovf ? raw_w :
                      value_w[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign sum_ext  = EXT_W'(sum_w);

    // Queue commands; a root pushes a zero sum.
    assign cmd.step     = accept && !root;
    assign cmd.clear    = accept && root;
    assign cmd.push_req = (child_count != '0);
    assign cmd.push_cnt = child_count;
    assign push_sum     = root ? '0 : sum_w;

    hps_queue #(
        .MAX_NODES  (MAX_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .push_sum (push_sum),
        .qstat    (qstat),
        .head_sum (head_sum)
    );

    // Status priority.
    always_comb
    begin
        if (!qstat.head_valid)
            status = ST_NO_PARENT;
        else if (qstat.push_drop)
            status = ST_QUEUE_FULL;
        else if (ovf)
            status = ST_SATURATED;
        else if (s_tlast && qstat.left_pending)
            status = ST_PENDING;
        else
            status = ST_OK;
    end

    // Output stage valid.
    always_comb
    begin
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output word.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_sum_reg    <= sum_ext[31:0];
            out_last_reg   <= s_tlast;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    // A non-root node always leaves a word in the output stage.
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> m_tvalid)
        else $error("accepted node produced no result word");

    // A root item alone never creates a result word.
    a_root_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear && !m_tvalid |=> !m_tvalid)
        else $error("root item produced a result word");

    // No node is taken while a word is stuck in the output stage.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !accept)
        else $error("input accepted over a stalled result");

endmodule
